/* hdl/mnes_pkg.sv */
// Shared types, codes and multiply microcode for the nearest-entry search.
// Used by the channel interfaces and the top level; no dependencies.
package mnes_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         class_code;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] cov_xx;
        logic signed [23:0] cov_xy;
        logic signed [23:0] cov_xz;
        logic signed [23:0] cov_yy;
        logic signed [23:0] cov_yz;
        logic signed [23:0] cov_zz;
        logic signed [31:0] distance_limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_index;
        logic [31:0] distance;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         cls;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [23:0] cxx;
        logic signed [23:0] cxy;
        logic signed [23:0] cxz;
        logic signed [23:0] cyy;
        logic signed [23:0] cyz;
        logic signed [23:0] czz;
    } t_entry;

    // working register file slots
    localparam int NREG = 21;
    localparam int REG_W = $clog2(NREG);
    localparam logic [REG_W-1:0] R_DX  = 5'd0,  R_DY  = 5'd1,  R_DZ  = 5'd2;
    localparam logic [REG_W-1:0] R_XX  = 5'd3,  R_XY  = 5'd4,  R_XZ  = 5'd5;
    localparam logic [REG_W-1:0] R_YY  = 5'd6,  R_YZ  = 5'd7,  R_ZZ  = 5'd8;
    localparam logic [REG_W-1:0] R_A00 = 5'd9,  R_A01 = 5'd10, R_A02 = 5'd11;
    localparam logic [REG_W-1:0] R_A11 = 5'd12, R_A12 = 5'd13, R_A22 = 5'd14;
    localparam logic [REG_W-1:0] R_PXX = 5'd15, R_PYY = 5'd16, R_PZZ = 5'd17;
    localparam logic [REG_W-1:0] R_PXY = 5'd18, R_PXZ = 5'd19, R_PYZ = 5'd20;

    typedef struct packed {
        logic             clr;
        logic             sub;
        logic [REG_W-1:0] a;
        logic [REG_W-1:0] b;
        logic             wr;
        logic [REG_W-1:0] dst;
        logic             det;
    } t_op;

    localparam int OP_N = 30;
    localparam int PC_W = $clog2(OP_N);
    localparam logic [PC_W-1:0] OP_LAST = PC_W'(OP_N - 1);

    function automatic t_op mk(input logic clr, input logic sub,
                               input logic [REG_W-1:0] a, input logic [REG_W-1:0] b,
                               input logic wr, input logic [REG_W-1:0] dst,
                               input logic det);
        t_op o;
        o.clr = clr; o.sub = sub; o.a = a; o.b = b;
        o.wr = wr; o.dst = dst; o.det = det;
        return o;
    endfunction

    // adjugate, distance products, determinant, quadratic form
    function automatic t_op ucode(input logic [PC_W-1:0] pc);
        t_op o;
        o = mk(1'b1, 1'b0, R_DX, R_DX, 1'b0, R_DX, 1'b0);
        case (pc)
            5'd0:  o = mk(1'b1, 1'b0, R_YY,  R_ZZ,  1'b0, R_DX,  1'b0);
            5'd1:  o = mk(1'b0, 1'b1, R_YZ,  R_YZ,  1'b1, R_A00, 1'b0);
            5'd2:  o = mk(1'b1, 1'b0, R_XZ,  R_YZ,  1'b0, R_DX,  1'b0);
            5'd3:  o = mk(1'b0, 1'b1, R_XY,  R_ZZ,  1'b1, R_A01, 1'b0);
            5'd4:  o = mk(1'b1, 1'b0, R_XY,  R_YZ,  1'b0, R_DX,  1'b0);
            5'd5:  o = mk(1'b0, 1'b1, R_XZ,  R_YY,  1'b1, R_A02, 1'b0);
            5'd6:  o = mk(1'b1, 1'b0, R_XX,  R_ZZ,  1'b0, R_DX,  1'b0);
            5'd7:  o = mk(1'b0, 1'b1, R_XZ,  R_XZ,  1'b1, R_A11, 1'b0);
            5'd8:  o = mk(1'b1, 1'b0, R_XY,  R_XZ,  1'b0, R_DX,  1'b0);
            5'd9:  o = mk(1'b0, 1'b1, R_XX,  R_YZ,  1'b1, R_A12, 1'b0);
            5'd10: o = mk(1'b1, 1'b0, R_XX,  R_YY,  1'b0, R_DX,  1'b0);
            5'd11: o = mk(1'b0, 1'b1, R_XY,  R_XY,  1'b1, R_A22, 1'b0);
            5'd12: o = mk(1'b1, 1'b0, R_DX,  R_DX,  1'b1, R_PXX, 1'b0);
            5'd13: o = mk(1'b1, 1'b0, R_DY,  R_DY,  1'b1, R_PYY, 1'b0);
            5'd14: o = mk(1'b1, 1'b0, R_DZ,  R_DZ,  1'b1, R_PZZ, 1'b0);
            5'd15: o = mk(1'b1, 1'b0, R_DX,  R_DY,  1'b1, R_PXY, 1'b0);
            5'd16: o = mk(1'b1, 1'b0, R_DX,  R_DZ,  1'b1, R_PXZ, 1'b0);
            5'd17: o = mk(1'b1, 1'b0, R_DY,  R_DZ,  1'b1, R_PYZ, 1'b0);
            5'd18: o = mk(1'b1, 1'b0, R_XX,  R_A00, 1'b0, R_DX,  1'b0);
            5'd19: o = mk(1'b0, 1'b0, R_XY,  R_A01, 1'b0, R_DX,  1'b0);
            5'd20: o = mk(1'b0, 1'b0, R_XZ,  R_A02, 1'b0, R_DX,  1'b1);
            5'd21: o = mk(1'b1, 1'b0, R_PXX, R_A00, 1'b0, R_DX,  1'b0);
            5'd22: o = mk(1'b0, 1'b0, R_PYY, R_A11, 1'b0, R_DX,  1'b0);
            5'd23: o = mk(1'b0, 1'b0, R_PZZ, R_A22, 1'b0, R_DX,  1'b0);
            5'd24: o = mk(1'b0, 1'b0, R_PXY, R_A01, 1'b0, R_DX,  1'b0);
            5'd25: o = mk(1'b0, 1'b0, R_PXY, R_A01, 1'b0, R_DX,  1'b0);
            5'd26: o = mk(1'b0, 1'b0, R_PXZ, R_A02, 1'b0, R_DX,  1'b0);
            5'd27: o = mk(1'b0, 1'b0, R_PXZ, R_A02, 1'b0, R_DX,  1'b0);
            5'd28: o = mk(1'b0, 1'b0, R_PYZ, R_A12, 1'b0, R_DX,  1'b0);
            5'd29: o = mk(1'b0, 1'b0, R_PYZ, R_A12, 1'b0, R_DX,  1'b0);
            default: o = mk(1'b1, 1'b0, R_DX, R_DX, 1'b0, R_DX, 1'b0);
        endcase
        return o;
    endfunction

endpackage

/* hdl/mnes_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on mnes_pkg.
interface mnes_in_if import mnes_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mnes_out_if import mnes_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/mahalanobis_nearest_entry_search.sv */
// Mahalanobis nearest-entry search: entry table memory, shared 64x17 MAC,
// restoring divider and scan sequencer. Depends on mnes_pkg and mnes_if.
//
//  channel  dir  payload      transfer when
//  i_req    in   t_in_item    i_req.valid & i_req.ready
//  o_rsp    out  t_out_item   o_rsp.valid & o_rsp.ready
//
// Clear, add and other kinds: accept, then output register load. Query per
// entry: fetch, load, 120 MAC steps, check, 32 divide steps, compare, advance.
// Check skips the divide when it settles the result; on det <= 0 it goes to
// advance, as load does for another class. The single MAC (30 products, 4 digit
// steps each) sets the rate. Reset empties the table at once; no clearing pass.
// A new request is taken while a result waits in the output register; a second
// result holds the sequencer in S_DONE until the output register drains.
module mahalanobis_nearest_entry_search import mnes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mnes_in_if.sink   i_req,
    mnes_out_if.source o_rsp
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FETCH = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_NEXT  = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_best;
    logic                r_found;
    logic [32:0]         r_gate;
    t_in_item            r_q;
    t_entry              r_mem [MAX_ENTRIES];
    t_entry              r_rd;
    logic signed [63:0]  r_v [NREG];
    logic [PC_W-1:0]     r_pc;
    logic [1:0]          r_dig;
    logic signed [127:0] r_acc;
    logic signed [127:0] r_det;
    logic signed [127:0] r_num;
    logic [127:0]        r_rem;
    logic [127:0]        r_dsh;
    logic [31:0]         r_quo;
    logic [4:0]          r_bit;
    logic [31:0]         r_cand;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_ovalid;

    t_op                 w_op;
    logic [15:0]         w_seg;
    logic signed [16:0]  w_sdig;
    logic signed [80:0]  w_prod;
    logic signed [127:0] w_term;
    logic signed [127:0] n_acc;
    logic                w_acc_in;
    logic                w_we;
    logic [127:0]        w_n16;
    logic [127:0]        w_d32;
    logic [CNT_W-1:0]    w_nidx;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc_in    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    assign w_we = w_acc_in && (i_req.data.kind == KIND_ADD)
                  && (r_count < CNT_W'(MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IDX_W-1:0]] <= '{i_req.data.class_code,
                i_req.data.pos_x, i_req.data.pos_y, i_req.data.pos_z,
                i_req.data.cov_xx, i_req.data.cov_xy, i_req.data.cov_xz,
                i_req.data.cov_yy, i_req.data.cov_yz, i_req.data.cov_zz};
        end
        r_rd <= r_mem[r_idx];
    end

    always_comb begin
        w_op   = ucode(r_pc);
        w_seg  = r_v[w_op.b][{r_dig, 4'b0000} +: 16];
        w_sdig = (r_dig == 2'd3) ? {w_seg[15], w_seg} : {1'b0, w_seg};
        w_prod = r_v[w_op.a] * w_sdig;
        w_term = {{47{w_prod[80]}}, w_prod} <<< {r_dig, 4'b0000};
        if (w_op.clr && r_dig == 2'd0) begin
            n_acc = w_op.sub ? -w_term : w_term;
        end else begin
            n_acc = w_op.sub ? r_acc - w_term : r_acc + w_term;
        end
        w_n16  = 128'(r_num) << 16;
        w_d32  = 128'(r_det) << 32;
        w_nidx = CNT_W'(r_idx) + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_idx    <= '0;
            r_pc     <= '0;
            r_dig    <= '0;
            r_bit    <= '0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || o_rsp.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_q     <= i_req.data;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_gate  <= (i_req.data.distance_limit <= 0) ? {1'b1, 32'd0}
                                   : {i_req.data.distance_limit[31:0], 1'b0};
                        case (i_req.data.kind)
                            KIND_CLEAR: begin
                                r_count <= '0;
                                r_res   <= '{ST_OK, 5'd0, 32'd0};
                                r_state <= S_DONE;
                            end
                            KIND_ADD: begin
                                if (w_we) begin
                                    r_res   <= '{ST_OK, r_count[IDX_W-1:0], 32'd0};
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_res   <= '{ST_FULL, 5'd0, 32'd0};
                                end
                                r_state <= S_DONE;
                            end
                            KIND_QUERY: r_state <= (r_count == '0) ? S_FIN : S_FETCH;
                            default: begin
                                r_res   <= '{ST_NOMATCH, 5'd0, 32'd0};
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FETCH: r_state <= S_LOAD;
                S_LOAD: begin
                    if (r_q.class_code != 8'd0 && r_q.class_code != r_rd.cls) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_v[R_DX] <= 64'(r_rd.px - 25'(r_q.pos_x));
                        r_v[R_DY] <= 64'(r_rd.py - 25'(r_q.pos_y));
                        r_v[R_DZ] <= 64'(r_rd.pz - 25'(r_q.pos_z));
                        r_v[R_XX] <= 64'(r_rd.cxx + 25'(r_q.cov_xx));
                        r_v[R_XY] <= 64'(r_rd.cxy + 25'(r_q.cov_xy));
                        r_v[R_XZ] <= 64'(r_rd.cxz + 25'(r_q.cov_xz));
                        r_v[R_YY] <= 64'(r_rd.cyy + 25'(r_q.cov_yy));
                        r_v[R_YZ] <= 64'(r_rd.cyz + 25'(r_q.cov_yz));
                        r_v[R_ZZ] <= 64'(r_rd.czz + 25'(r_q.cov_zz));
                        r_pc    <= '0;
                        r_dig   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    r_dig <= r_dig + 2'd1;
                    if (r_dig == 2'd3) begin
                        if (w_op.wr) r_v[w_op.dst] <= n_acc[63:0];
                        if (w_op.det) r_det <= n_acc;
                        if (r_pc == OP_LAST) begin
                            r_num   <= n_acc;
                            r_state <= S_CHECK;
                        end else begin
                            r_pc <= r_pc + PC_W'(1);
                        end
                    end
                end
                S_CHECK: begin
                    if (r_det[127] || r_det == '0) begin
                        r_state <= S_NEXT;
                    end else if (r_num[127]) begin
                        r_cand  <= '0;
                        r_state <= S_CMP;
                    end else if (w_n16 >= w_d32) begin
                        r_cand  <= '1;
                        r_state <= S_CMP;
                    end else begin
                        r_rem   <= w_n16;
                        r_dsh   <= 128'(r_det) << 31;
                        r_bit   <= 5'd31;
                        r_quo   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) r_rem <= r_rem - r_dsh;
                    r_quo <= {r_quo[30:0], (r_rem >= r_dsh)};
                    r_dsh <= r_dsh >> 1;
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_cand  <= {r_quo[30:0], (r_rem >= r_dsh)};
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if ({1'b0, r_cand} < r_gate) begin
                        r_gate  <= {1'b0, r_cand};
                        r_best  <= r_idx;
                        r_found <= 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (w_nidx >= r_count) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= w_nidx[IDX_W-1:0];
                        r_state <= S_FETCH;
                    end
                end
                S_FIN: begin
                    r_res   <= '{(r_found ? ST_OK : ST_NOMATCH),
                                 (r_found ? r_best : 5'd0),
                                 (r_gate[32] ? 32'hFFFF_FFFF : r_gate[31:0])};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_out    <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_req.data.kind == KIND_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty table");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_pc <= OP_LAST)) else $error("microcode overrun");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("result lost while output stalled");

endmodule
